[design/nps_pkg.sv]
// ----------------------------------------------------------------------------
// nps_pkg
// Shared types and constants for the normalized priority sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package nps_pkg;

   // Default capacity of the request stores.
   localparam int MAX_REQUESTS_DEF = 64;

   // Fixed field widths.
   localparam int LOAD_W  = 16;
   localparam int TIME_W  = 20;
   localparam int Q16_W   = 17;
   localparam int ALPHA_W = 9;
   localparam int INDEX_W = 6;

   // Full weight, 1.0 in alpha units.
   localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

   // One request beat.
   typedef struct packed {
      logic [LOAD_W-1:0] load_value;
      logic [TIME_W-1:0] start_time;
      logic              last_request;
   } req_type;

   // One result beat.
   typedef struct packed {
      logic [INDEX_W-1:0] request_index;
      logic [Q16_W-1:0]   norm_load;
      logic [Q16_W-1:0]   norm_time;
      logic [Q16_W-1:0]   priority_res;
      logic               dropped_some;
      logic               last_result;
   } rsp_type;

endpackage

`default_nettype wire

[design/normalized_priority_sort.sv]
// ----------------------------------------------------------------------------
// normalized_priority_sort
// Collects a batch of requests, normalizes load and start time, and emits
// the batch in ascending weighted priority order.
// ----------------------------------------------------------------------------
// Requests are taken one per cycle while busy is low. The beat carrying
// last_request closes the set and raises busy. The block then scores each
// stored request with two 16-step shift-subtract dividers, ranks the scores
// through the single score memory read port, and recomputes L and T with the
// dividers before each result beat. Results appear as one-cycle strobes on
// rsp_valid and cannot be held off; busy falls in the same cycle that the
// final result is on the ports, so the next request can be taken there.
`default_nettype none

module normalized_priority_sort
   import nps_pkg::*;
#(
   parameter int MaxRequests = MAX_REQUESTS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [ALPHA_W-1:0] csr_wr_data,
   input  wire logic               start,
   output logic                    busy,
   input  wire req_type            req_payload,
   output logic                    rsp_valid,
   output rsp_type                 rsp_payload
);

   localparam int IW = $clog2(MaxRequests);
   localparam int CW = $clog2(MaxRequests + 1);
   localparam logic [CW-1:0] CAP = CW'(MaxRequests);

   typedef enum logic [3:0] {
      S_LOAD, S_CRD, S_DINIT, S_DIV, S_CMUL, S_CSUM,
      S_RRD, S_RKEY, S_RISS, S_RCMP,
      S_EORD, S_EIDX, S_ERD, S_EOUT
   } state_type;

   state_type state_ff;

   // Memories.
   logic [LOAD_W-1:0]  load_mem  [MaxRequests];
   logic [TIME_W-1:0]  time_mem  [MaxRequests];
   logic [Q16_W-1:0]   score_mem [MaxRequests];
   logic [IW-1:0]      order_mem [MaxRequests];
   logic [LOAD_W-1:0]  load_rd_ff;
   logic [TIME_W-1:0]  time_rd_ff;
   logic [Q16_W-1:0]   score_rd_ff;
   logic [IW-1:0]      order_rd_ff;

   // Set state.
   logic [CW-1:0]      count_ff;
   logic               overflow_ff;
   logic [LOAD_W-1:0]  least_ff, greatest_ff;
   logic [TIME_W-1:0]  earliest_ff, latest_ff;
   logic [ALPHA_W-1:0] alpha_ff;

   // Walk counters.
   logic [CW-1:0]      i_ff, j_ff, k_ff, rank_ff;
   logic [IW-1:0]      idx_ff;
   logic               emit_ff;
   logic [Q16_W-1:0]   key_ff;

   // Divider state.
   logic [3:0]         step_ff;
   logic [LOAD_W:0]    rl_ff;
   logic [TIME_W:0]    rt_ff;
   logic [Q16_W-1:0]   ql_ff, qt_ff;

   // Score pipeline.
   logic [ALPHA_W+Q16_W-1:0] pl_ff, pt_ff;

   // Combinational helpers.
   logic               accept;
   logic [IW-1:0]      rd_addr;
   logic [IW-1:0]      score_raddr;
   logic [LOAD_W-1:0]  num_l, den_l;
   logic [TIME_W-1:0]  num_t, den_t;
   logic [LOAD_W:0]    rl_sh, rl_in;
   logic [TIME_W:0]    rt_sh, rt_in;
   logic               bit_l, bit_t;
   logic [ALPHA_W-1:0] alpha_sat;
   logic [ALPHA_W+Q16_W:0] sum_w;
   logic               before_key;
   logic [CW-1:0]      rank_pos;
   logic [CW+INDEX_W-1:0] idx_wide;

   assign accept = start && !busy;
   assign busy   = (state_ff != S_LOAD);

   // Read addresses for the request memories and the score memory.
   assign rd_addr = emit_ff ? idx_ff : i_ff[IW-1:0];
   always_comb begin
      unique case (state_ff)
         S_RRD:   score_raddr = i_ff[IW-1:0];
         S_RISS:  score_raddr = j_ff[IW-1:0];
         default: score_raddr = idx_ff;
      endcase
   end

   // Normalization operands.
   assign num_l = load_rd_ff - least_ff;
   assign den_l = greatest_ff - least_ff;
   assign num_t = latest_ff - time_rd_ff;
   assign den_t = latest_ff - earliest_ff;

   // One restoring step for each divider.
   assign rl_sh = {rl_ff[LOAD_W-1:0], 1'b0};
   assign bit_l = (rl_sh >= {1'b0, den_l});
   assign rl_in = bit_l ? (rl_sh - {1'b0, den_l}) : rl_sh;
   assign rt_sh = {rt_ff[TIME_W-1:0], 1'b0};
   assign bit_t = (rt_sh >= {1'b0, den_t});
   assign rt_in = bit_t ? (rt_sh - {1'b0, den_t}) : rt_sh;

   // Weighted sum of the registered products.
   assign alpha_sat = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;
   assign sum_w     = {1'b0, pl_ff} + {1'b0, pt_ff};

   // Stable ranking: earlier entries win ties.
   assign before_key = (score_rd_ff < key_ff) ||
                       ((score_rd_ff == key_ff) && (j_ff < i_ff));
   assign rank_pos   = rank_ff + CW'(before_key);

   assign idx_wide = {{CW{1'b0}}, {(INDEX_W){1'b0}}} | (CW+INDEX_W)'(idx_ff);

   // Request memories: written while loading, read while scoring or emitting.
   always_ff @(posedge clock) begin
      if (accept && (count_ff < CAP)) begin
         load_mem[count_ff[IW-1:0]] <= req_payload.load_value;
         time_mem[count_ff[IW-1:0]] <= req_payload.start_time;
      end
      load_rd_ff <= load_mem[rd_addr];
      time_rd_ff <= time_mem[rd_addr];
   end

   // Score memory.
   always_ff @(posedge clock) begin
      if (state_ff == S_CSUM) begin
         score_mem[i_ff[IW-1:0]] <= sum_w[Q16_W+7:8];
      end
      score_rd_ff <= score_mem[score_raddr];
   end

   // Order memory: slot rank holds the arrival index.
   always_ff @(posedge clock) begin
      if ((state_ff == S_RCMP) && (j_ff + 1'b1 == count_ff)) begin
         order_mem[rank_pos[IW-1:0]] <= i_ff[IW-1:0];
      end
      order_rd_ff <= order_mem[k_ff[IW-1:0]];
   end

   // Control sequencer and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_LOAD;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
         least_ff    <= '1;
         greatest_ff <= '0;
         earliest_ff <= '1;
         latest_ff   <= '0;
         alpha_ff    <= ALPHA_W'(128);
         emit_ff     <= 1'b0;
         rsp_valid   <= 1'b0;
         i_ff        <= '0;
         j_ff        <= '0;
         k_ff        <= '0;
         rank_ff     <= '0;
         step_ff     <= '0;
      end else begin
         rsp_valid <= 1'b0;
         if (csr_wr_en) begin
            alpha_ff <= csr_wr_data;
         end
         unique case (state_ff)
            S_LOAD: begin
               if (accept) begin
                  if (count_ff < CAP) begin
                     count_ff <= count_ff + 1'b1;
                     if (req_payload.load_value < least_ff) least_ff <= req_payload.load_value;
                     if (req_payload.load_value > greatest_ff) begin
                        greatest_ff <= req_payload.load_value;
                     end
                     if (req_payload.start_time < earliest_ff) begin
                        earliest_ff <= req_payload.start_time;
                     end
                     if (req_payload.start_time > latest_ff) latest_ff <= req_payload.start_time;
                  end else begin
                     overflow_ff <= 1'b1;
                  end
                  if (req_payload.last_request) begin
                     i_ff     <= '0;
                     emit_ff  <= 1'b0;
                     state_ff <= S_CRD;
                  end
               end
            end
            S_CRD: begin
               state_ff <= S_DINIT;
            end
            // Integer bit is set only when the operand equals the span.
            S_DINIT: begin
               step_ff <= '0;
               if (den_l == '0) begin
                  ql_ff <= '0;
                  rl_ff <= '0;
               end else if (num_l == den_l) begin
                  ql_ff <= {1'b1, {(Q16_W-1){1'b0}}};
                  rl_ff <= '0;
               end else begin
                  ql_ff <= '0;
                  rl_ff <= {1'b0, num_l};
               end
               if (den_t == '0) begin
                  qt_ff <= '0;
                  rt_ff <= '0;
               end else if (num_t == den_t) begin
                  qt_ff <= {1'b1, {(Q16_W-1){1'b0}}};
                  rt_ff <= '0;
               end else begin
                  qt_ff <= '0;
                  rt_ff <= {1'b0, num_t};
               end
               state_ff <= S_DIV;
            end
            S_DIV: begin
               step_ff <= step_ff + 1'b1;
               if (den_l != '0) begin
                  rl_ff <= rl_in;
                  ql_ff <= {ql_ff[Q16_W-1], ql_ff[Q16_W-3:0], bit_l};
               end
               if (den_t != '0) begin
                  rt_ff <= rt_in;
                  qt_ff <= {qt_ff[Q16_W-1], qt_ff[Q16_W-3:0], bit_t};
               end
               if (step_ff == 4'd15) begin
                  state_ff <= emit_ff ? S_EOUT : S_CMUL;
               end
            end
            S_CMUL: begin
               pl_ff    <= alpha_sat * ql_ff;
               pt_ff    <= (ALPHA_ONE - alpha_sat) * qt_ff;
               state_ff <= S_CSUM;
            end
            S_CSUM: begin
               if (i_ff + 1'b1 == count_ff) begin
                  i_ff     <= '0;
                  state_ff <= S_RRD;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_CRD;
               end
            end
            // Rank pass: count entries that sort ahead of entry i.
            S_RRD: begin
               state_ff <= S_RKEY;
            end
            S_RKEY: begin
               key_ff   <= score_rd_ff;
               j_ff     <= '0;
               rank_ff  <= '0;
               state_ff <= S_RISS;
            end
            S_RISS: begin
               state_ff <= S_RCMP;
            end
            S_RCMP: begin
               rank_ff <= rank_ff + CW'(before_key);
               if (j_ff + 1'b1 == count_ff) begin
                  if (i_ff + 1'b1 == count_ff) begin
                     k_ff     <= '0;
                     emit_ff  <= 1'b1;
                     state_ff <= S_EORD;
                  end else begin
                     i_ff     <= i_ff + 1'b1;
                     state_ff <= S_RRD;
                  end
               end else begin
                  j_ff     <= j_ff + 1'b1;
                  state_ff <= S_RISS;
               end
            end
            // Emit pass.
            S_EORD: begin
               state_ff <= S_EIDX;
            end
            S_EIDX: begin
               idx_ff   <= order_rd_ff;
               state_ff <= S_ERD;
            end
            S_ERD: begin
               state_ff <= S_DINIT;
            end
            S_EOUT: begin
               rsp_valid                 <= 1'b1;
               rsp_payload.request_index <= idx_wide[INDEX_W-1:0];
               rsp_payload.norm_load     <= ql_ff;
               rsp_payload.norm_time     <= qt_ff;
               rsp_payload.priority_res  <= score_rd_ff;
               rsp_payload.dropped_some  <= overflow_ff;
               rsp_payload.last_result   <= (k_ff + 1'b1 == count_ff);
               if (k_ff + 1'b1 == count_ff) begin
                  count_ff    <= '0;
                  overflow_ff <= 1'b0;
                  least_ff    <= '1;
                  greatest_ff <= '0;
                  earliest_ff <= '1;
                  latest_ff   <= '0;
                  emit_ff     <= 1'b0;
                  state_ff    <= S_LOAD;
               end else begin
                  k_ff     <= k_ff + 1'b1;
                  state_ff <= S_EORD;
               end
            end
            default: state_ff <= S_LOAD;
         endcase
      end
   end

endmodule

`default_nettype wire

[design/nps_checker.sv]
// ----------------------------------------------------------------------------
// nps_checker
// Port-level checks for the normalized priority sorter.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_checker
   import nps_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_payload
);

   // Result beats before the final one come while a closed set is being worked.
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last_result |-> busy)
      else $error("result beat while idle");

   // Result beats are separated by the divider pass.
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last_result |=> !rsp_valid)
      else $error("back-to-back result beats");

   // The final beat comes with the block already released.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.last_result |-> !busy)
      else $error("still busy during the final beat");

   // Busy only rises after a request beat.
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start)) else $error("busy rose without a request");

endmodule

bind normalized_priority_sort nps_checker u_nps_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_valid   (rsp_valid),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

[tb/nps_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nps_scoreboard
// Watches the request, result and register ports of the priority sorter,
// keeps its own model of the batch, and compares every result beat with the
// oldest predicted one.
// ----------------------------------------------------------------------------
module nps_scoreboard
   import nps_pkg::*;
#(
   parameter int Capacity = MAX_REQUESTS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [ALPHA_W-1:0] csr_wr_data,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire req_type            req_payload,
   input  wire logic               rsp_valid,
   input  wire rsp_type            rsp_payload,
   output int                      mismatch_count,
   output int                      pending_count
);

   // Shadow copy of the batch state.
   logic [ALPHA_W-1:0] alpha_reg;
   logic [LOAD_W-1:0]  batch_load [Capacity];
   logic [TIME_W-1:0]  batch_time [Capacity];
   int                 batch_count;
   logic [LOAD_W-1:0]  load_min, load_max;
   logic [TIME_W-1:0]  time_min, time_max;
   logic               batch_dropped;
   rsp_type            ranked_beats [$];

   function automatic logic [Q16_W-1:0] scale_q16(input logic [31:0] num,
                                                   input logic [31:0] den);
      logic [63:0] wide;
      if (den == 0) begin
         return '0;
      end
      wide = {16'd0, num, 16'd0} / {32'd0, den};
      return wide[Q16_W-1:0];
   endfunction

   task automatic clear_batch();
      batch_count   = 0;
      load_min      = '1;
      load_max      = '0;
      time_min      = '1;
      time_max      = '0;
      batch_dropped = 1'b0;
   endtask

   // Score all stored requests, rank them stably, and queue the result beats.
   task automatic rank_batch();
      logic [Q16_W-1:0] norm_l [Capacity];
      logic [Q16_W-1:0] norm_t [Capacity];
      logic [31:0]      score  [Capacity];
      int               order  [Capacity];
      logic [31:0]      weight;
      int               key, j;
      rsp_type          beat;
      weight = (alpha_reg > ALPHA_ONE) ? 32'd256 : 32'(alpha_reg);
      for (int i = 0; i < batch_count; i++) begin
         norm_l[i] = scale_q16(32'(batch_load[i] - load_min), 32'(load_max - load_min));
         norm_t[i] = scale_q16(32'(time_max - batch_time[i]), 32'(time_max - time_min));
         score[i]  = (weight * 32'(norm_l[i]) + (32'd256 - weight) * 32'(norm_t[i])) >> 8;
         order[i]  = i;
      end
      for (int i = 1; i < batch_count; i++) begin
         key = order[i];
         j   = i;
         while (j > 0 && score[order[j-1]] > score[key]) begin
            order[j] = order[j-1];
            j--;
         end
         order[j] = key;
      end
      for (int i = 0; i < batch_count; i++) begin
         beat.request_index = order[i][INDEX_W-1:0];
         beat.norm_load     = norm_l[order[i]];
         beat.norm_time     = norm_t[order[i]];
         beat.priority_res  = score[order[i]][Q16_W-1:0];
         beat.dropped_some  = batch_dropped;
         beat.last_result   = (i == batch_count - 1);
         ranked_beats = {ranked_beats, beat};
      end
   endtask

   task automatic flag_mismatch(input string what, input rsp_type want, input rsp_type got);
      if (mismatch_count < 10) begin
         $display("%0t checker: %s exp idx=%0d L=%h T=%h P=%h drop=%b last=%b", $realtime,
                  what, want.request_index, want.norm_load, want.norm_time,
                  want.priority_res, want.dropped_some, want.last_result);
         $display("%0t checker: %s got idx=%0d L=%h T=%h P=%h drop=%b last=%b", $realtime,
                  what, got.request_index, got.norm_load, got.norm_time,
                  got.priority_res, got.dropped_some, got.last_result);
      end
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         alpha_reg      = ALPHA_W'(128);
         mismatch_count = 0;
         ranked_beats.delete();
         clear_batch();
      end else begin
         // Register write.
         if (csr_wr_en) begin
            alpha_reg = csr_wr_data;
         end
         // Result beat compare.
         if (rsp_valid) begin
            if (ranked_beats.size() == 0) begin
               want = '0;
               flag_mismatch("unexpected beat", want, rsp_payload);
            end else begin
               want = ranked_beats.pop_front();
               if (rsp_payload !== want) begin
                  flag_mismatch("field mismatch", want, rsp_payload);
               end
            end
         end
         // Accepted request beat.
         if (start && !busy) begin
            if (batch_count < Capacity) begin
               batch_load[batch_count] = req_payload.load_value;
               batch_time[batch_count] = req_payload.start_time;
               if (req_payload.load_value < load_min) load_min = req_payload.load_value;
               if (req_payload.load_value > load_max) load_max = req_payload.load_value;
               if (req_payload.start_time < time_min) time_min = req_payload.start_time;
               if (req_payload.start_time > time_max) time_max = req_payload.start_time;
               batch_count++;
            end else begin
               batch_dropped = 1'b1;
            end
            if (req_payload.last_request) begin
               rank_batch();
               clear_batch();
            end
         end
      end
      pending_count = ranked_beats.size();
   end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives batches of requests into the priority sorter with random bursts and
// gaps, changes the weight between batches, and reports the verdict of the
// checker that runs beside the block.
// ----------------------------------------------------------------------------
module tb;
   import nps_pkg::*;

   localparam int Capacity = MAX_REQUESTS_DEF;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic [ALPHA_W-1:0] csr_wr_data = '0;
   logic               start = 1'b0;
   logic               busy;
   req_type            req_payload = '0;
   logic               rsp_valid;
   rsp_type            rsp_payload;
   int                 mismatch_count;
   int                 pending_count;
   int                 items_sent = 0;
   int                 burst_left = 0;

   always #1 clock = ~clock;

   normalized_priority_sort #(.MaxRequests(Capacity)) uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   nps_scoreboard #(.Capacity(Capacity)) u_scoreboard (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .start          (start),
      .busy           (busy),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_payload    (rsp_payload),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // Wait until the batch is drained and the block is idle.
   task automatic wait_idle();
      while (pending_count != 0 || busy) begin
         @(negedge clock);
      end
   endtask

   task automatic write_alpha(input logic [ALPHA_W-1:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Send one beat, opening a new burst after a random gap when needed.
   task automatic send_beat(input req_type beat);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      start       <= 1'b1;
      req_payload <= beat;
      do @(posedge clock); while (busy);
      @(negedge clock);
      burst_left--;
      items_sent++;
   endtask

   // One batch of the given size; style picks how loads and times spread.
   task automatic send_batch(input int size, input int style);
      req_type beat;
      logic [LOAD_W-1:0] base_load;
      logic [TIME_W-1:0] base_time;
      base_load = LOAD_W'($urandom);
      base_time = TIME_W'($urandom);
      for (int i = 0; i < size; i++) begin
         case (style)
            0: begin
               beat.load_value = LOAD_W'($urandom);
               beat.start_time = TIME_W'($urandom);
            end
            1: begin
               // Few distinct values, so equal scores are common.
               beat.load_value = base_load + LOAD_W'($urandom_range(0, 2));
               beat.start_time = base_time + TIME_W'($urandom_range(0, 2));
            end
            2: begin
               beat.load_value = base_load;
               beat.start_time = base_time;
            end
            default: begin
               beat.load_value = $urandom_range(0, 1) ? '1 : '0;
               beat.start_time = $urandom_range(0, 1) ? '1 : '0;
            end
         endcase
         beat.last_request = (i == size - 1);
         send_beat(beat);
      end
      start <= 1'b0;
   endtask

   initial begin
      #4000000;
      $display("tb: FAIL");
      $finish;
   end

   initial begin
      int size;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed batches: single request, extremes, equal values, weight limits.
      send_batch(1, 0);
      send_batch(2, 3);
      write_alpha(ALPHA_W'(0));
      send_batch(3, 2);
      send_batch(4, 3);
      write_alpha(ALPHA_ONE);
      send_batch(4, 1);
      write_alpha(ALPHA_W'(511));
      send_batch(4, 0);
      write_alpha(ALPHA_W'(257));
      send_batch(3, 1);
      write_alpha(ALPHA_W'(128));
      send_batch(4, 0);

      // Full store, then overflow with the closing request dropped.
      send_batch(Capacity, 0);
      write_alpha(ALPHA_W'(64));
      send_batch(Capacity + 3, 1);

      // Random batches, mostly small.
      while (items_sent < 480) begin
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
               0: write_alpha(ALPHA_W'(0));
               1: write_alpha(ALPHA_ONE);
               default: write_alpha(ALPHA_W'($urandom));
            endcase
         end
         case ($urandom_range(0, 19))
            0: size = Capacity + $urandom_range(1, 4);
            1: size = $urandom_range(20, Capacity);
            default: size = $urandom_range(1, 10);
         endcase
         send_batch(size, $urandom_range(0, 4) < 3 ? $urandom_range(0, 1)
                                                   : $urandom_range(2, 3));
      end

      // Drain, then watch a while for stray beats.
      wait_idle();
      repeat (200) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
